FILE: rtl/core/vna_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex normal accumulator package
// Shared widths, command codes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package vna_pkg;

   localparam int MaxVertices = 1024;
   localparam int SumWidth    = 24;
   localparam int IdxWidth    = 10;
   localparam int AddrWidth   = $clog2(MaxVertices);
   localparam int PosWidth    = 16;
   localparam int NrmWidth    = 16;
   localparam int PosRowWidth = 3 * PosWidth;
   localparam int SumRowWidth = 3 * SumWidth;
   localparam int ProdWidth   = 36;
   localparam int CrossWidth  = 37;
   localparam int MagWidth    = 37;
   localparam int SqWidth     = 62;
   localparam int RootWidth   = 31;

   typedef enum logic [1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_TRI   = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   // Controller to datapath.
   typedef struct packed {
      logic       latch_req;    // capture the request fields
      logic       pos_write;    // write the load position
      logic [1:0] pos_rd_sel;   // 0 corner a, 1 corner b, 2 corner c
      logic [1:0] pos_cap_sel;  // which corner register takes read data
      logic       pos_cap;
      logic       cross_step;   // one cross product partial step
      logic       cross_init;
      logic [1:0] sum_sel;      // corner whose sum is addressed
      logic       sum_cap;      // capture sum read data as a vector
      logic       norm_start;
      logic       sum_write;    // write saturated sum at selected corner
      logic       clr_write;    // clear sweep write
      logic       clr_init;
      logic       rsp_load;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic cross_done;
      logic norm_done;
      logic norm_zero;
      logic clr_last;
      logic in_range;       // all used indices in the table
   } sts_type;

endpackage

FILE: rtl/core/vna_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request and response channels
// Valid/ready interfaces carrying the request and response payloads.
// ----------------------------------------------------------------------------
interface vna_req_if;
   logic                   valid;
   logic                   ready;
   logic [1:0]             func;
   logic [9:0]             corner_a;
   logic [9:0]             corner_b;
   logic [9:0]             corner_c;
   logic signed [15:0]     pos_x;
   logic signed [15:0]     pos_y;
   logic signed [15:0]     pos_z;
   modport source (output valid, func, corner_a, corner_b, corner_c, pos_x, pos_y,
                   pos_z, input ready);
   modport sink (input valid, func, corner_a, corner_b, corner_c, pos_x, pos_y,
                 pos_z, output ready);
endinterface

interface vna_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] normal_z;
   logic               zero_sum;
   modport source (output valid, normal_x, normal_y, normal_z, zero_sum, input ready);
   modport sink (input valid, normal_x, normal_y, normal_z, zero_sum, output ready);
endinterface

FILE: rtl/core/vna_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write and one read per cycle on a shared address, registered read data.
// ----------------------------------------------------------------------------
module vna_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write through the port, registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/core/vna_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector normaliser
// Scales a signed three-component vector to a rounded Q1.14 unit vector
// using a bit-serial square root and three parallel restoring dividers.
// ----------------------------------------------------------------------------
module vna_norm (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [vna_pkg::CrossWidth-1:0]  vec_x,
   input  logic signed [vna_pkg::CrossWidth-1:0]  vec_y,
   input  logic signed [vna_pkg::CrossWidth-1:0]  vec_z,
   output logic                                   done,
   output logic                                   is_zero,
   output logic signed [vna_pkg::NrmWidth-1:0]    nrm_x,
   output logic signed [vna_pkg::NrmWidth-1:0]    nrm_y,
   output logic signed [vna_pkg::NrmWidth-1:0]    nrm_z
);
   localparam int MW = vna_pkg::MagWidth;
   localparam int SW = vna_pkg::SqWidth;
   localparam int RW = vna_pkg::RootWidth;
   localparam int DW = 47;  // mag*16384 + len/2 fits below 2^45, plus window headroom

   typedef enum logic [6:0] {
      N_IDLE  = 7'b0000001,
      N_SHIFT = 7'b0000010,
      N_SQ    = 7'b0000100,
      N_ROOT  = 7'b0001000,
      N_DIVI  = 7'b0010000,
      N_DIV   = 7'b0100000,
      N_DONE  = 7'b1000000
   } nstate_type;

   nstate_type        state_ff, state_in;
   logic [MW-1:0]     mag_ff [3];
   logic [MW-1:0]     mag_in [3];
   logic [2:0]        neg_ff, neg_in;
   logic [1:0]        sq_idx_ff, sq_idx_in;
   logic [SW-1:0]     sq_acc_ff, sq_acc_in;
   logic [SW-1:0]     rem_ff, rem_in;
   logic [RW-1:0]     root_ff, root_in;
   logic [4:0]        rcnt_ff, rcnt_in;
   logic [DW-1:0]     drem_ff [3];
   logic [DW-1:0]     drem_in [3];
   logic [15:0]       quo_ff [3];
   logic [15:0]       quo_in [3];
   logic [5:0]        dcnt_ff, dcnt_in;
   logic              zero_ff, zero_in;
   logic [MW-1:0]     mx;
   logic [30:0]       msq;
   logic [SW-1:0]     trial;
   logic [1:0]        pair;
   logic [SW-1:0]     rem_sh;

   always_comb begin
      mx = mag_ff[0];
      if (mag_ff[1] > mx) mx = mag_ff[1];
      if (mag_ff[2] > mx) mx = mag_ff[2];
      msq  = mag_ff[sq_idx_ff][30:0];
      pair = sq_acc_ff[2*rcnt_ff +: 2];
      rem_sh = {rem_ff[SW-3:0], pair};
      trial  = {{(SW-RW-2){1'b0}}, root_ff, 2'b01};
   end

   // Sequencer: align magnitudes, sum squares, root, then divide bit by bit.
   always_comb begin
      state_in  = state_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      sq_idx_in = sq_idx_ff;
      sq_acc_in = sq_acc_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      rcnt_in   = rcnt_ff;
      drem_in   = drem_ff;
      quo_in    = quo_ff;
      dcnt_in   = dcnt_ff;
      zero_in   = zero_ff;
      unique case (state_ff)
         N_IDLE: begin
            if (start) begin
               neg_in    = {vec_z[MW-1], vec_y[MW-1], vec_x[MW-1]};
               mag_in[0] = vec_x[MW-1] ? MW'(-vec_x) : MW'(vec_x);
               mag_in[1] = vec_y[MW-1] ? MW'(-vec_y) : MW'(vec_y);
               mag_in[2] = vec_z[MW-1] ? MW'(-vec_z) : MW'(vec_z);
               state_in  = N_SHIFT;
            end
         end
         N_SHIFT: begin
            if (mx == '0) begin
               zero_in  = 1'b1;
               for (int i = 0; i < 3; i++) quo_in[i] = '0;
               state_in = N_DONE;
            end else if (mx >= (MW'(1) << 30)) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else if (mx < (MW'(1) << 29)) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 1;
            end else begin
               zero_in   = 1'b0;
               sq_idx_in = '0;
               sq_acc_in = '0;
               state_in  = N_SQ;
            end
         end
         N_SQ: begin
            sq_acc_in = sq_acc_ff + SW'(msq * msq);
            if (sq_idx_ff == 2'd2) begin
               rem_in   = '0;
               root_in  = '0;
               rcnt_in  = 5'd30;
               state_in = N_ROOT;
            end else begin
               sq_idx_in = sq_idx_ff + 2'd1;
            end
         end
         N_ROOT: begin
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[RW-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[RW-2:0], 1'b0};
            end
            if (rcnt_ff == '0) state_in = N_DIVI;
            else rcnt_in = rcnt_ff - 5'd1;
         end
         N_DIVI: begin
            for (int i = 0; i < 3; i++) begin
               drem_in[i] = {mag_ff[i][30:0], 14'd0} + DW'(root_ff[RW-1:1]);
               quo_in[i]  = '0;
            end
            dcnt_in  = '0;
            state_in = N_DIV;
         end
         N_DIV: begin
            // Quotient below 2^15; long division keeps remainder in the top
            // bits: compare high window against the divisor each step.
            for (int i = 0; i < 3; i++) begin
               if (drem_ff[i][DW-1 -: RW+1] >= {1'b0, root_ff}) begin
                  drem_in[i][DW-1 -: RW+1] = drem_ff[i][DW-1 -: RW+1]
                                            - {1'b0, root_ff};
                  quo_in[i] = {quo_ff[i][14:0], 1'b1};
               end else begin
                  quo_in[i] = {quo_ff[i][14:0], 1'b0};
               end
               if (dcnt_ff != 6'd15) begin
                  drem_in[i] = {drem_in[i][DW-2:0], 1'b0};
               end
            end
            if (dcnt_ff == 6'd15) state_in = N_DONE;
            else dcnt_in = dcnt_ff + 6'd1;
         end
         N_DONE: begin
            state_in = N_IDLE;
         end
         default: state_in = N_IDLE;
      endcase
   end

   // Divider note: the first compare window, bits 46..15 of the dividend,
   // holds the dividend shifted right by 15, which gives quotient bit 15
   // against the 31-bit divisor; each later step moves one bit lower.

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      sq_idx_ff <= sq_idx_in;
      sq_acc_ff <= sq_acc_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      rcnt_ff   <= rcnt_in;
      drem_ff   <= drem_in;
      quo_ff    <= quo_in;
      dcnt_ff   <= dcnt_in;
      zero_ff   <= zero_in;
   end

   assign done    = (state_ff == N_DONE);
   assign is_zero = zero_ff;
   assign nrm_x   = neg_ff[0] ? -$signed(quo_ff[0]) : $signed(quo_ff[0]);
   assign nrm_y   = neg_ff[1] ? -$signed(quo_ff[1]) : $signed(quo_ff[1]);
   assign nrm_z   = neg_ff[2] ? -$signed(quo_ff[2]) : $signed(quo_ff[2]);
endmodule

FILE: rtl/core/vna_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex normal accumulator datapath
// Position and sum memories, cross product unit, normaliser and response
// register, all steered by the controller.
// ----------------------------------------------------------------------------
module vna_datapath (
   input  logic                clock,
   input  logic                reset,
   input  vna_pkg::cmd_type    cmd,
   output vna_pkg::sts_type    sts,
   input  logic [1:0]          req_func,
   input  logic [9:0]          req_corner_a,
   input  logic [9:0]          req_corner_b,
   input  logic [9:0]          req_corner_c,
   input  logic signed [15:0]  req_pos_x,
   input  logic signed [15:0]  req_pos_y,
   input  logic signed [15:0]  req_pos_z,
   output logic signed [15:0]  rsp_normal_x,
   output logic signed [15:0]  rsp_normal_y,
   output logic signed [15:0]  rsp_normal_z,
   output logic                rsp_zero_sum
);
   localparam int AW = vna_pkg::AddrWidth;
   localparam int SW = vna_pkg::SumWidth;
   localparam int CW = vna_pkg::CrossWidth;
   localparam int PW = vna_pkg::ProdWidth;

   logic [1:0]          func_ff;
   logic [9:0]          idx_ff [3];
   logic signed [15:0]  pin_ff [3];
   logic signed [15:0]  cor_ff [3][3];
   logic signed [17:0]  e1 [3];
   logic signed [17:0]  e2 [3];
   logic [2:0]          xstep_ff;
   logic signed [CW-1:0] cross_ff [3];
   logic signed [PW-1:0] prod_ff;
   logic                prod_v_ff;
   logic [1:0]          prod_dst_ff;
   logic                prod_sub_ff;
   logic [AW-1:0]       pos_addr, sum_addr;
   logic [vna_pkg::PosRowWidth-1:0] pos_rd;
   logic [vna_pkg::SumRowWidth-1:0] sum_rd, sum_wr;
   logic signed [SW-1:0] sum_vec_ff [3];
   logic signed [CW-1:0] nvec [3];
   logic                nstart_ff;
   logic                ndone, nzero;
   logic signed [15:0]  nx, ny, nz;
   logic signed [15:0]  nrm_ff [3];
   logic [AW-1:0]       clr_ff;
   logic signed [15:0]  rx_ff, ry_ff, rz_ff;
   logic                rzero_ff;
   logic signed [SW:0]  sum_t [3];
   logic signed [SW-1:0] sat [3];
   logic signed [17:0]  ma, mb;
   logic [9:0]          cur_idx;

   localparam logic signed [SW:0] SatHi = (SW+1)'((1 << (SW-1)) - 1);
   localparam logic signed [SW:0] SatLo = -SatHi - (SW+1)'(1);

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         func_ff   <= req_func;
         idx_ff[0] <= req_corner_a;
         idx_ff[1] <= req_corner_b;
         idx_ff[2] <= req_corner_c;
         pin_ff[0] <= req_pos_x;
         pin_ff[1] <= req_pos_y;
         pin_ff[2] <= req_pos_z;
      end
   end

   // Address selection for both memories.
   always_comb begin
      cur_idx  = idx_ff[cmd.pos_rd_sel];
      pos_addr = AW'(cur_idx);
      sum_addr = cmd.clr_write ? clr_ff : AW'(idx_ff[cmd.sum_sel]);
   end

   vna_ram #(.Width(vna_pkg::PosRowWidth), .Depth(vna_pkg::MaxVertices)) u_pos_ram (
      .clock   (clock),
      .wr_en   (cmd.pos_write),
      .addr    (pos_addr),
      .wr_data ({pin_ff[2], pin_ff[1], pin_ff[0]}),
      .rd_data (pos_rd)
   );

   // Saturating add of the face normal.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_t[i] = {sum_vec_ff[i][SW-1], sum_vec_ff[i]} + (SW+1)'(nrm_ff[i]);
         if (sum_t[i] > SatHi) sat[i] = SW'(SatHi);
         else if (sum_t[i] < SatLo) sat[i] = SW'(SatLo);
         else sat[i] = SW'(sum_t[i]);
      end
      sum_wr = cmd.clr_write ? '0 : {sat[2], sat[1], sat[0]};
   end

   vna_ram #(.Width(vna_pkg::SumRowWidth), .Depth(vna_pkg::MaxVertices)) u_sum_ram (
      .clock   (clock),
      .wr_en   (cmd.sum_write | cmd.clr_write),
      .addr    (sum_addr),
      .wr_data (sum_wr),
      .rd_data (sum_rd)
   );

   // Corner capture and sum capture.
   always_ff @(posedge clock) begin
      if (cmd.pos_cap) begin
         cor_ff[cmd.pos_cap_sel][0] <= $signed(pos_rd[15:0]);
         cor_ff[cmd.pos_cap_sel][1] <= $signed(pos_rd[31:16]);
         cor_ff[cmd.pos_cap_sel][2] <= $signed(pos_rd[47:32]);
      end
      if (cmd.sum_cap) begin
         sum_vec_ff[0] <= $signed(sum_rd[SW-1:0]);
         sum_vec_ff[1] <= $signed(sum_rd[2*SW-1:SW]);
         sum_vec_ff[2] <= $signed(sum_rd[3*SW-1:2*SW]);
      end
   end

   // Edge vectors.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1[i] = 18'(cor_ff[1][i]) - 18'(cor_ff[0][i]);
         e2[i] = 18'(cor_ff[2][i]) - 18'(cor_ff[0][i]);
      end
   end

   // One shared 18x18 multiplier, six products, registered before accumulate.
   always_comb begin
      unique case (xstep_ff)
         3'd0: begin ma = e1[1]; mb = e2[2]; end
         3'd1: begin ma = e1[2]; mb = e2[1]; end
         3'd2: begin ma = e1[2]; mb = e2[0]; end
         3'd3: begin ma = e1[0]; mb = e2[2]; end
         3'd4: begin ma = e1[0]; mb = e2[1]; end
         3'd5: begin ma = e1[1]; mb = e2[0]; end
         default: begin ma = '0; mb = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xstep_ff  <= '0;
         prod_v_ff <= 1'b0;
      end else if (cmd.cross_init) begin
         xstep_ff  <= '0;
         prod_v_ff <= 1'b0;
      end else if (cmd.cross_step) begin
         prod_v_ff <= (xstep_ff < 3'd6);
         if (xstep_ff != 3'd7) xstep_ff <= xstep_ff + 3'd1;
      end else begin
         prod_v_ff <= 1'b0;
      end
      prod_ff     <= ma * mb;
      prod_dst_ff <= 2'(xstep_ff >> 1);
      prod_sub_ff <= xstep_ff[0];
      if (cmd.cross_init) begin
         for (int i = 0; i < 3; i++) cross_ff[i] <= '0;
      end else if (prod_v_ff) begin
         if (prod_sub_ff) cross_ff[prod_dst_ff] <= cross_ff[prod_dst_ff] - CW'(prod_ff);
         else cross_ff[prod_dst_ff] <= cross_ff[prod_dst_ff] + CW'(prod_ff);
      end
   end

   // Normaliser input: cross product for a triangle, sum for a read.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nvec[i] = (func_ff == vna_pkg::FUNC_TRI) ? cross_ff[i] : CW'(sum_vec_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) nstart_ff <= 1'b0;
      else nstart_ff <= cmd.norm_start;
   end

   vna_norm u_norm (
      .clock   (clock),
      .reset   (reset),
      .start   (nstart_ff),
      .vec_x   (nvec[0]),
      .vec_y   (nvec[1]),
      .vec_z   (nvec[2]),
      .done    (ndone),
      .is_zero (nzero),
      .nrm_x   (nx),
      .nrm_y   (ny),
      .nrm_z   (nz)
   );

   always_ff @(posedge clock) begin
      if (ndone) begin
         nrm_ff[0] <= nx;
         nrm_ff[1] <= ny;
         nrm_ff[2] <= nz;
      end
   end

   // Clear sweep counter.
   always_ff @(posedge clock) begin
      if (reset || cmd.clr_init) clr_ff <= '0;
      else if (cmd.clr_write) clr_ff <= clr_ff + AW'(1);
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         if (sts.in_range && !nzero) begin
            rx_ff <= nrm_ff[0];
            ry_ff <= nrm_ff[1];
            rz_ff <= nrm_ff[2];
            rzero_ff <= 1'b0;
         end else begin
            rx_ff <= '0;
            ry_ff <= '0;
            rz_ff <= '0;
            rzero_ff <= 1'b1;
         end
      end
   end

   assign sts.cross_done = (xstep_ff == 3'd7) && !prod_v_ff;
   assign sts.norm_done  = ndone;
   assign sts.norm_zero  = nzero;
   assign sts.clr_last   = (clr_ff == AW'(vna_pkg::MaxVertices - 1));
   assign sts.in_range   = (32'(idx_ff[0]) < vna_pkg::MaxVertices) &&
                           ((func_ff != vna_pkg::FUNC_TRI) ||
                            ((32'(idx_ff[1]) < vna_pkg::MaxVertices) &&
                             (32'(idx_ff[2]) < vna_pkg::MaxVertices)));

   assign rsp_normal_x = rx_ff;
   assign rsp_normal_y = ry_ff;
   assign rsp_normal_z = rz_ff;
   assign rsp_zero_sum = rzero_ff;
endmodule

FILE: rtl/core/vna_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex normal accumulator controller
// Sequences memory reads, the cross product, normalisation, the three sum
// updates, the clear sweep and the response handshake.
// ----------------------------------------------------------------------------
module vna_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output vna_pkg::cmd_type   cmd,
   input  vna_pkg::sts_type   sts
);
   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_DECODE = 14'b00000000000010,
      S_PRD    = 14'b00000000000100,
      S_PCAP   = 14'b00000000001000,
      S_CROSS  = 14'b00000000010000,
      S_SRD    = 14'b00000000100000,
      S_SCAP   = 14'b00000001000000,
      S_NSTART = 14'b00000010000000,
      S_NWAIT  = 14'b00000100000000,
      S_URD    = 14'b00001000000000,
      S_UCAP   = 14'b00010000000000,
      S_UWR    = 14'b00100000000000,
      S_CLEAR  = 14'b01000000000000,
      S_RSP    = 14'b10000000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] func_ff, func_in;
   logic [1:0] k_ff, k_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Next-state and command decode.
   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.pos_rd_sel  = k_ff;
      cmd.pos_cap_sel = k_ff;
      cmd.sum_sel     = k_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               func_in  = req_func;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            k_in = '0;
            unique case (func_ff)
               vna_pkg::FUNC_LOAD: begin
                  cmd.pos_rd_sel = 2'd0;
                  cmd.pos_write  = sts.in_range;
                  state_in = S_IDLE;
               end
               vna_pkg::FUNC_TRI: state_in = sts.in_range ? S_PRD : S_IDLE;
               vna_pkg::FUNC_READ: begin
                  if (sts.in_range) begin
                     cmd.sum_sel = 2'd0;
                     state_in = S_SRD;
                  end else begin
                     state_in = S_RSP;
                  end
               end
               default: begin
                  cmd.clr_init = 1'b1;
                  state_in = S_CLEAR;
               end
            endcase
         end
         S_PRD: state_in = S_PCAP;
         S_PCAP: begin
            cmd.pos_cap = 1'b1;
            if (k_ff == 2'd2) begin
               cmd.cross_init = 1'b1;
               state_in = S_CROSS;
            end else begin
               k_in = k_ff + 2'd1;
               state_in = S_PRD;
            end
         end
         S_CROSS: begin
            cmd.cross_step = 1'b1;
            if (sts.cross_done) state_in = S_NSTART;
         end
         S_SRD: begin
            cmd.sum_sel = 2'd0;
            state_in = S_SCAP;
         end
         S_SCAP: begin
            cmd.sum_cap = 1'b1;
            state_in = S_NSTART;
         end
         S_NSTART: begin
            cmd.norm_start = 1'b1;
            state_in = S_NWAIT;
         end
         S_NWAIT: begin
            if (sts.norm_done) begin
               k_in = '0;
               if (func_ff == vna_pkg::FUNC_READ) state_in = S_RSP;
               else if (sts.norm_zero) state_in = S_IDLE;
               else state_in = S_URD;
            end
         end
         S_URD: state_in = S_UCAP;
         S_UCAP: begin
            cmd.sum_cap = 1'b1;
            state_in = S_UWR;
         end
         S_UWR: begin
            cmd.sum_write = 1'b1;
            if (k_ff == 2'd2) begin
               state_in = S_IDLE;
            end else begin
               k_in = k_ff + 2'd1;
               state_in = S_URD;
            end
         end
         S_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_RSP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Reset starts a sweep that zeroes every sum before the first request.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         func_ff      <= vna_pkg::FUNC_LOAD;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         func_ff      <= func_in;
         k_ff         <= k_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // A request is only taken in the idle state.
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   // A response is only loaded from the response state.
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> state_ff == S_RSP) else $error("response load out of place");
   // Sum writes and clear writes never coincide.
   a_sum_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.sum_write && cmd.clr_write)) else $error("sum write clash");
   // Response valid rises only after a load.
   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.rsp_load)) else $error("response without load");
endmodule

FILE: rtl/core/vertex_normal_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex normal accumulator
// Builds smooth vertex normals from triangle face normals in fixed point.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the req channel (valid/ready); func selects a
// position load, a triangle add, a normal read or a sum clear. Only a read
// produces a response on the rsp channel.
// The block works on one request at a time. A load is a single position
// write. A triangle takes three position reads, six products on one
// shared multiplier, then the normaliser (one alignment shift a cycle, up
// to 29 of them, three squares, a 31-step bit-serial root and 16-step
// restoring division of all three components), then, unless the normal is
// zero, three read-modify-write sum updates. A read runs one sum read and
// the same normaliser. A clear sweeps the sum memory one entry a cycle.
// After reset the block runs the same sweep with ready low, so every sum
// starts at zero; the position memory holds nothing meaningful until
// loaded.
// The response sits in an output register; a stalled receiver holds it
// while the next request is already being worked on, and a further read
// waits only at its own response hand-off.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator (
   input  logic  clock,
   input  logic  reset,
   vna_req_if.sink   req,
   vna_rsp_if.source rsp
);
   vna_pkg::cmd_type cmd;
   vna_pkg::sts_type sts;

   vna_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .req_func  (req.func),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   vna_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_func     (req.func),
      .req_corner_a (req.corner_a),
      .req_corner_b (req.corner_b),
      .req_corner_c (req.corner_c),
      .req_pos_x    (req.pos_x),
      .req_pos_y    (req.pos_y),
      .req_pos_z    (req.pos_z),
      .rsp_normal_x (rsp.normal_x),
      .rsp_normal_y (rsp.normal_y),
      .rsp_normal_z (rsp.normal_z),
      .rsp_zero_sum (rsp.zero_sum)
   );
endmodule

FILE: verif/tb_vertex_normal_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex normal accumulator testbench
// Drives position loads, triangle adds, normal reads and sum clears through
// the request channel. A behavioural normaliser and sum table predict each
// read response not typed into a directed row; each is compared field by
// field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_vertex_normal_accumulator;

   typedef struct {
      vna_pkg::func_type  fn;
      logic [9:0]         a, b, c;
      logic signed [15:0] x, y, z;
      bit                 fixed;     // response typed into the table row
      logic signed [15:0] nx, ny, nz;
      logic               zs;
   } request_type;

   typedef struct packed {
      logic signed [15:0] x, y, z;
      logic               zs;
   } normal_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vna_req_if req_ch ();
   vna_rsp_if rsp_ch ();

   vertex_normal_accumulator dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Bench copy of the block's tables.
   logic signed [15:0] pos_tab [vna_pkg::MaxVertices][3];
   longint             sum_tab [vna_pkg::MaxVertices][3];
   bit                 loaded  [vna_pkg::MaxVertices];
   int                 loaded_idx [$];

   normal_type expected_normals [$];
   int      failures;
   int      idle_cycles;

   localparam int IdleLimit = 5000;

   // Clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Mismatch reporting.
   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      failures++;
   endtask

   // Scale a vector to a Q1.14 unit normal; a zero vector gives the flag.
   function automatic normal_type unit_normal(input longint vx, input longint vy,
                                              input longint vz);
      longint vin [3];
      longint unsigned mag [3];
      bit neg [3];
      longint unsigned mx, s, root, bitv, q;
      logic signed [15:0] res [3];
      normal_type r;
      vin[0] = vx; vin[1] = vy; vin[2] = vz;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = vin[i] < 0;
         mag[i] = neg[i] ? -vin[i] : vin[i];
         if (mag[i] > mx) mx = mag[i];
         res[i] = '0;
      end
      if (mx == 0) begin
         r = '{x: 16'sd0, y: 16'sd0, z: 16'sd0, zs: 1'b1};
         return r;
      end
      // Align the largest magnitude into [2^29, 2^30).
      while (mx >= (64'd1 << 30)) begin
         mx >>= 1;
         for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
         mx <<= 1;
         for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      // Bit-by-bit integer square root.
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= root + bitv) begin
            s -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      for (int i = 0; i < 3; i++) begin
         q = (mag[i] * 16384 + root / 2) / root;
         res[i] = neg[i] ? -q : q;
      end
      r = '{x: res[0], y: res[1], z: res[2], zs: 1'b0};
      return r;
   endfunction

   function automatic longint sat_add(input longint acc, input longint inc);
      longint hi, lo, t;
      hi = (longint'(1) << (vna_pkg::SumWidth - 1)) - 1;
      lo = -hi - 1;
      t  = acc + inc;
      if (t > hi) t = hi;
      if (t < lo) t = lo;
      return t;
   endfunction

   // Update the bench tables for one accepted request; returns the response
   // of a read.
   function automatic normal_type predict_normal(input request_type rq);
      longint e1 [3], e2 [3];
      longint cx, cy, cz;
      int idx [3];
      normal_type n;
      n = '0;
      case (rq.fn)
         vna_pkg::FUNC_LOAD: begin
            pos_tab[rq.a][0] = rq.x;
            pos_tab[rq.a][1] = rq.y;
            pos_tab[rq.a][2] = rq.z;
            if (!loaded[rq.a]) loaded_idx.push_back(rq.a);
            loaded[rq.a] = 1'b1;
         end
         vna_pkg::FUNC_TRI: begin
            for (int i = 0; i < 3; i++) begin
               e1[i] = longint'(pos_tab[rq.b][i]) - longint'(pos_tab[rq.a][i]);
               e2[i] = longint'(pos_tab[rq.c][i]) - longint'(pos_tab[rq.a][i]);
            end
            cx = e1[1] * e2[2] - e1[2] * e2[1];
            cy = e1[2] * e2[0] - e1[0] * e2[2];
            cz = e1[0] * e2[1] - e1[1] * e2[0];
            n = unit_normal(cx, cy, cz);
            // A degenerate triangle adds nothing.
            if (!n.zs) begin
               idx[0] = rq.a; idx[1] = rq.b; idx[2] = rq.c;
               for (int k = 0; k < 3; k++) begin
                  sum_tab[idx[k]][0] = sat_add(sum_tab[idx[k]][0], n.x);
                  sum_tab[idx[k]][1] = sat_add(sum_tab[idx[k]][1], n.y);
                  sum_tab[idx[k]][2] = sat_add(sum_tab[idx[k]][2], n.z);
               end
            end
         end
         vna_pkg::FUNC_READ: begin
            n = unit_normal(sum_tab[rq.a][0], sum_tab[rq.a][1], sum_tab[rq.a][2]);
         end
         default: begin
            for (int i = 0; i < vna_pkg::MaxVertices; i++)
               for (int j = 0; j < 3; j++) sum_tab[i][j] = 0;
         end
      endcase
      return n;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Hand one request to the block and record what it should return.
   task automatic issue(input request_type rq);
      normal_type n;
      int g;
      @(negedge clock);
      req_ch.func     = rq.fn;
      req_ch.corner_a = rq.a;
      req_ch.corner_b = rq.b;
      req_ch.corner_c = rq.c;
      req_ch.pos_x    = rq.x;
      req_ch.pos_y    = rq.y;
      req_ch.pos_z    = rq.z;
      req_ch.valid    = 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      n = predict_normal(rq);
      if (rq.fn == vna_pkg::FUNC_READ) begin
         if (rq.fixed) n = '{x: rq.nx, y: rq.ny, z: rq.nz, zs: rq.zs};
         expected_normals.push_back(n);
      end
      g = pick_gap();
      if (g > 0) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (g - 1) @(negedge clock);
      end
   endtask

   function automatic logic signed [15:0] rand_pos();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'sh7FFF;
      if (r == 1) return -16'sh8000;
      if (r < 5) return 16'($urandom);
      return 16'($signed($urandom_range(0, 2047)) - 1024);
   endfunction

   function automatic logic [9:0] rand_loaded();
      return loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
   endfunction

   // Receiver: random stalls, response checked at the accepting edge.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= (pick_gap() == 0);
      end
   end

   always @(posedge clock) begin
      normal_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_normals.size() == 0) begin
            report("response with nothing expected");
         end else begin
            want = expected_normals.pop_front();
            if (rsp_ch.normal_x !== want.x)
               report($sformatf("normal_x %0d, expected %0d", rsp_ch.normal_x, want.x));
            if (rsp_ch.normal_y !== want.y)
               report($sformatf("normal_y %0d, expected %0d", rsp_ch.normal_y, want.y));
            if (rsp_ch.normal_z !== want.z)
               report($sformatf("normal_z %0d, expected %0d", rsp_ch.normal_z, want.z));
            if (rsp_ch.zero_sum !== want.zs)
               report($sformatf("zero_sum %0b, expected %0b", rsp_ch.zero_sum, want.zs));
         end
      end
   end

   // Watchdog on cycles with no hand-off on either channel.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("watchdog expired at %0t", $realtime);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Directed requests: clear first, then extremes and special cases.
   request_type directed [] = '{
      '{vna_pkg::FUNC_CLEAR, 10'd0,    10'd0,    10'd0,    16'sd0, 16'sd0, 16'sd0,
        0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
      // Zero sum on read.
      '{vna_pkg::FUNC_READ,  10'd5,    10'd0,    10'd0,    16'sd0, 16'sd0, 16'sd0,
        1, 16'sd0, 16'sd0, 16'sd0, 1'b1},
      '{vna_pkg::FUNC_LOAD,  10'd0,    10'd0,    10'd0,    16'sd0, 16'sd0, 16'sd0,
        0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
      '{vna_pkg::FUNC_LOAD,  10'd1,    10'd0,    10'd0,    16'sd256, 16'sd0, 16'sd0,
        0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
      '{vna_pkg::FUNC_LOAD,  10'd2,    10'd0,    10'd0,    16'sd0, 16'sd256, 16'sd0,
        0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
      '{vna_pkg::FUNC_TRI,   10'd0,    10'd1,    10'd2,    16'sd0, 16'sd0, 16'sd0,
        0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
      '{vna_pkg::FUNC_READ,  10'd0,    10'd0,    10'd0,    16'sd0, 16'sd0, 16'sd0,
        1, 16'sd0, 16'sd0, 16'sd16384, 1'b0},
      // Degenerate triangle with a repeated corner.
      '{vna_pkg::FUNC_TRI,   10'd0,    10'd0,    10'd1,    16'sd0, 16'sd0, 16'sd0,
        0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
      '{vna_pkg::FUNC_READ,  10'd1,    10'd0,    10'd0,    16'sd0, 16'sd0, 16'sd0,
        1, 16'sd0, 16'sd0, 16'sd16384, 1'b0},
      '{vna_pkg::FUNC_LOAD,  10'd1023, 10'd0,    10'd0,
        16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
        0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
      '{vna_pkg::FUNC_LOAD,  10'd1022, 10'd1023, 10'd1023,
        -16'sh8000, -16'sh8000, -16'sh8000,
        0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
      '{vna_pkg::FUNC_LOAD,  10'd1021, 10'd0,    10'd0,
        16'sh7FFF, -16'sh8000, 16'sd0,
        0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
      '{vna_pkg::FUNC_TRI,   10'd1023, 10'd1022, 10'd1021, 16'sd0, 16'sd0, 16'sd0,
        0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
      '{vna_pkg::FUNC_READ,  10'd1023, 10'd0,    10'd0,    16'sd0, 16'sd0, 16'sd0,
        0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
      '{vna_pkg::FUNC_TRI,   10'd1,    10'd2,    10'd0,    16'sd0, 16'sd0, 16'sd0,
        0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
      '{vna_pkg::FUNC_READ,  10'd2,    10'd0,    10'd0,    16'sd0, 16'sd0, 16'sd0,
        1, 16'sd0, 16'sd0, 16'sd16384, 1'b0},
      '{vna_pkg::FUNC_TRI,   10'd2,    10'd1,    10'd0,    16'sd0, 16'sd0, 16'sd0,
        0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
      '{vna_pkg::FUNC_READ,  10'd1021, 10'd0,    10'd0,    16'sd0, 16'sd0, 16'sd0,
        0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
      '{vna_pkg::FUNC_CLEAR, 10'h3FF,  10'h3FF,  10'h3FF,
        16'shFFFF, 16'shFFFF, 16'shFFFF,
        0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
      '{vna_pkg::FUNC_READ,  10'd1022, 10'd0,    10'd0,    16'sd0, 16'sd0, 16'sd0,
        1, 16'sd0, 16'sd0, 16'sd0, 1'b1}
   };

   // Stimulus and end of run.
   initial begin
      request_type rq;
      int r;
      req_ch.valid    = 1'b0;
      req_ch.func     = vna_pkg::FUNC_LOAD;
      req_ch.corner_a = '0;
      req_ch.corner_b = '0;
      req_ch.corner_c = '0;
      req_ch.pos_x    = '0;
      req_ch.pos_y    = '0;
      req_ch.pos_z    = '0;
      for (int i = 0; i < vna_pkg::MaxVertices; i++) begin
         loaded[i] = 1'b0;
         for (int j = 0; j < 3; j++) begin
            sum_tab[i][j] = 0;
            pos_tab[i][j] = '0;
         end
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) issue(directed[i]);

      // Random part: a hot pool of vertices keeps sums growing to saturation.
      for (int n = 0; n < 930; n++) begin
         rq = '{vna_pkg::FUNC_LOAD, 10'($urandom), 10'($urandom), 10'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), 0, 0, 0, 0, 0};
         r = $urandom_range(0, 99);
         if (r < 22) begin
            rq.fn = vna_pkg::FUNC_LOAD;
            if ($urandom_range(0, 1)) rq.a = $urandom_range(0, 15);
            rq.x = rand_pos();
            rq.y = rand_pos();
            rq.z = rand_pos();
         end else if (r < 70) begin
            rq.fn = vna_pkg::FUNC_TRI;
            rq.a = rand_loaded();
            rq.b = rand_loaded();
            rq.c = rand_loaded();
         end else if (r < 99) begin
            rq.fn = vna_pkg::FUNC_READ;
            if ($urandom_range(0, 3) != 0) rq.a = rand_loaded();
         end else begin
            rq.fn = vna_pkg::FUNC_CLEAR;
         end
         issue(rq);
         // Hold off once until every response has come back.
         if (n == 400) begin
            @(negedge clock);
            req_ch.valid = 1'b0;
            wait (expected_normals.size() == 0);
         end
      end

      @(negedge clock);
      req_ch.valid = 1'b0;
      wait (expected_normals.size() == 0);
      repeat (200) @(posedge clock);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
